### sv/touch_toggle_phase_dimmer_defines.svh
// Assertion macros for the touch toggle phase dimmer.
`ifndef TOUCH_TOGGLE_PHASE_DIMMER_DEFINES_SVH
`define TOUCH_TOGGLE_PHASE_DIMMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTPD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dimmer assertion failed");

// Next-cycle implication, disabled during reset.
`define TTPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dimmer assertion failed");

`endif

### sv/ttpd_pkg.sv
// Types and constants shared by the touch toggle phase dimmer.
`timescale 1ns / 1ps
package ttpd_pkg;

	localparam int CAL_SAMPLES_DEF = 20;
	localparam int CAL_SUM_W       = 21;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 16;

	typedef enum logic [1:0] {
		CMD_TOUCH = 2'd0,
		CMD_ZERO  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FOCUS       = 3'd0,
		CFG_DEADBAND    = 3'd1,
		CFG_PRESS       = 3'd2,
		CFG_RELEASE     = 3'd3,
		CFG_RELEARN     = 3'd4,
		CFG_FADE_ON     = 3'd5,
		CFG_FADE_OFF    = 3'd6,
		CFG_OFF_LIMIT   = 3'd7
	} cfg_index_t;

	typedef struct packed {
		logic [15:0] focus_count;
		logic [7:0]  deadband;
		logic [9:0]  press_margin;
		logic [9:0]  release_margin;
		logic [15:0] relearn_limit;
		logic [7:0]  fade_on_step;
		logic [7:0]  fade_off_step;
		logic [14:0] off_delay_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] sample;
	} evt_t;

	typedef struct packed {
		logic fire;
		logic lamp_on;
		logic calibrating;
	} res_t;

	typedef struct packed {
		logic lamp_on;
		logic calibrating;
	} touch_st_t;

endpackage

### sv/ttpd_touch.sv
// Touch sample path: calibration average, deadband tracker, press detection and toggle.
`timescale 1ns / 1ps
module ttpd_touch import ttpd_pkg::*; #(
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [15:0] sample,
	input  cfg_t        cfg,
	output touch_st_t   st_cur,
	output touch_st_t   st_nxt
);

	localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
	localparam int SHIFT   = CAL_SUM_W + $clog2(CAL_SAMPLES);
	localparam int MULT_W  = SHIFT + 1;
	localparam int PROD_W  = CAL_SUM_W + MULT_W;
	localparam logic [MULT_W-1:0] MULT =
		MULT_W'(((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

	logic [CNT_W-1:0]     cal_count_q, cal_count_n;
	logic [CAL_SUM_W-1:0] cal_sum_q, cal_sum_n;
	logic [15:0]          baseline_q, baseline_n;
	logic [15:0]          tracked_q, tracked_n;
	logic [15:0]          press_q, press_n;
	logic [15:0]          release_q, release_n;
	logic                 toggle_q, toggle_n;
	logic [PROD_W-1:0]    prod;
	logic [16:0]          trk_hi;
	logic [16:0]          press_inc, release_inc;
	logic [15:0]          pm, rm, db;
	logic                 calibrating;

	assign pm          = 16'(cfg.press_margin);
	assign rm          = 16'(cfg.release_margin);
	assign db          = 16'(cfg.deadband);
	assign calibrating = cal_count_q < CNT_W'(CAL_SAMPLES);
	assign cal_sum_n   = calibrating ? (cal_sum_q + CAL_SUM_W'(sample)) : cal_sum_q;
	assign prod        = PROD_W'(cal_sum_n) * PROD_W'(MULT);
	assign trk_hi      = {1'b0, tracked_q} + 17'(db);
	assign press_inc   = {1'b0, press_q} + 17'd1;
	assign release_inc = {1'b0, release_q} + 17'd1;

	always_comb begin
		cal_count_n = cal_count_q;
		baseline_n  = baseline_q;
		tracked_n   = tracked_q;
		press_n     = press_q;
		release_n   = release_q;
		toggle_n    = toggle_q;
		if (calibrating) begin
			cal_count_n = cal_count_q + CNT_W'(1);
			if (cal_count_n >= CNT_W'(CAL_SAMPLES)) begin
				baseline_n = prod[SHIFT +: 16];
			end
		end else begin
			if ({1'b0, sample} > trk_hi || tracked_q < db || sample < tracked_q - db) begin
				tracked_n = sample;
			end
			if (baseline_q < pm || tracked_n < baseline_q - pm) begin
				release_n = '0;
				if (press_inc > {1'b0, cfg.relearn_limit}) begin
					press_n    = '0;
					baseline_n = tracked_n;
				end else begin
					press_n = press_inc[15:0];
				end
			end else if (baseline_q >= rm && tracked_n > baseline_q - rm) begin
				press_n = '0;
				if (release_inc > {1'b0, cfg.relearn_limit}) begin
					release_n  = '0;
					baseline_n = tracked_n;
				end else begin
					release_n = release_inc[15:0];
				end
			end
			if (press_n == cfg.focus_count) begin
				toggle_n = ~toggle_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_count_q <= '0;
			cal_sum_q   <= '0;
			baseline_q  <= '0;
			tracked_q   <= '0;
			press_q     <= '0;
			release_q   <= '0;
			toggle_q    <= 1'b0;
		end else if (en) begin
			cal_count_q <= cal_count_n;
			cal_sum_q   <= cal_sum_n;
			baseline_q  <= baseline_n;
			tracked_q   <= tracked_n;
			press_q     <= press_n;
			release_q   <= release_n;
			toggle_q    <= toggle_n;
		end
	end

	assign st_cur.lamp_on     = toggle_q;
	assign st_cur.calibrating = calibrating;
	assign st_nxt.lamp_on     = en ? toggle_n : toggle_q;
	assign st_nxt.calibrating = en ? (cal_count_n < CNT_W'(CAL_SAMPLES)) : calibrating;

endmodule

### sv/ttpd_phase.sv
// Phase-angle firing: mains period capture, fade delays and triac firing level.
`timescale 1ns / 1ps
module ttpd_phase import ttpd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en_zero,
	input  logic en_tick,
	input  logic lamp_on,
	input  cfg_t cfg,
	output logic fire_cur,
	output logic fire_nxt
);

	logic [15:0] tick_q, tick_n;
	logic [15:0] period_q, period_n;
	logic [15:0] on_delay_q, on_delay_n;
	logic [15:0] off_delay_q, off_delay_n;
	logic        fire_q, fire_n;
	logic [15:0] on_dec;
	logic [15:0] tick_inc;

	assign on_dec   = on_delay_q - 16'(cfg.fade_on_step);
	assign tick_inc = tick_q + 16'd1;

	always_comb begin
		tick_n      = tick_q;
		period_n    = period_q;
		on_delay_n  = on_delay_q;
		off_delay_n = off_delay_q;
		fire_n      = fire_q;
		if (en_zero) begin
			period_n = tick_q;
			tick_n   = '0;
			if (lamp_on) begin
				if (on_dec[15]) begin
					on_delay_n = 16'hFFFF;
					fire_n     = 1'b1;
				end else begin
					on_delay_n = on_dec;
					fire_n     = 1'b0;
				end
			end else begin
				fire_n = 1'b0;
				if ($signed(off_delay_q) <= $signed({1'b0, cfg.off_delay_limit})) begin
					off_delay_n = off_delay_q + 16'(cfg.fade_off_step);
				end
			end
		end else if (en_tick) begin
			tick_n = tick_inc;
			if (lamp_on) begin
				if ($signed(tick_inc) >= $signed(on_delay_q)) begin
					fire_n = 1'b1;
				end
				off_delay_n = on_delay_q;
			end else begin
				if (tick_inc == off_delay_q) begin
					fire_n = 1'b1;
				end
				on_delay_n = period_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			period_q    <= '0;
			on_delay_q  <= '0;
			off_delay_q <= '0;
			fire_q      <= 1'b0;
		end else begin
			tick_q      <= tick_n;
			period_q    <= period_n;
			on_delay_q  <= on_delay_n;
			off_delay_q <= off_delay_n;
			fire_q      <= fire_n;
		end
	end

	assign fire_cur = fire_q;
	assign fire_nxt = fire_n;

endmodule

### sv/touch_toggle_phase_dimmer.sv
// Top level of the touch toggle phase dimmer: handshakes, configuration and result register.
//
// Usage:
//   evt channel (evt_valid/evt_stall/evt) carries one event per transaction:
//   a touch sample, a mains zero cross or a timer tick. Every event yields
//   exactly one result transaction on the res channel (res_valid/res_stall/res)
//   holding the firing level, lamp state and calibration flag after it.
//   An accepted event passes through the input register and then the result
//   register before res_valid. Throughput is one event per cycle unless
//   res_stall holds a result; state updates per event, so each sees the last.
//   The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one of
//   eight registers per transaction and is always ready; write only while idle.
//   Reset clears all event state, loads the register defaults and empties
//   both stages; the first CAL_SAMPLES touch samples set the baseline.
//   When res_stall is high the result holds, the input register fills and
//   evt_stall rises only once both stages hold a transaction.
`timescale 1ns / 1ps
`include "touch_toggle_phase_dimmer_defines.svh"
module touch_toggle_phase_dimmer import ttpd_pkg::*; #(
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   evt_valid,
	output logic                   evt_stall,
	input  evt_t                   evt,
	output logic                   res_valid,
	input  logic                   res_stall,
	output res_t                   res,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      s1_valid_q;
	evt_t      evt_s1;
	logic      res_valid_q;
	res_t      res_q;
	logic      advance;
	logic      en_touch, en_zero, en_tick;
	logic      fire_cur, fire_nxt;
	touch_st_t st_cur, st_nxt;
	cmd_t      cmd_s1;

	assign cfg_ready = 1'b1;
	assign cmd_s1    = cmd_t'(evt_s1.cmd);
	assign advance   = s1_valid_q && (!res_valid_q || !res_stall);
	assign evt_stall = s1_valid_q && !advance;

	always_comb begin
		en_touch = 1'b0;
		en_zero  = 1'b0;
		en_tick  = 1'b0;
		unique case (cmd_s1)
			CMD_TOUCH: en_touch = advance;
			CMD_ZERO:  en_zero  = advance;
			CMD_TICK:  en_tick  = advance;
			CMD_NONE:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focus_count     <= 16'd1000;
			cfg_q.deadband        <= 8'd10;
			cfg_q.press_margin    <= 10'd50;
			cfg_q.release_margin  <= 10'd20;
			cfg_q.relearn_limit   <= 16'd5000;
			cfg_q.fade_on_step    <= 8'd2;
			cfg_q.fade_off_step   <= 8'd4;
			cfg_q.off_delay_limit <= 15'd160;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FOCUS:     cfg_q.focus_count     <= cfg_data;
				CFG_DEADBAND:  cfg_q.deadband        <= cfg_data[7:0];
				CFG_PRESS:     cfg_q.press_margin    <= cfg_data[9:0];
				CFG_RELEASE:   cfg_q.release_margin  <= cfg_data[9:0];
				CFG_RELEARN:   cfg_q.relearn_limit   <= cfg_data;
				CFG_FADE_ON:   cfg_q.fade_on_step    <= cfg_data[7:0];
				CFG_FADE_OFF:  cfg_q.fade_off_step   <= cfg_data[7:0];
				CFG_OFF_LIMIT: cfg_q.off_delay_limit <= cfg_data[14:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt_valid && !evt_stall) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			evt_s1 <= evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.fire        <= fire_nxt;
			res_q.lamp_on     <= st_nxt.lamp_on;
			res_q.calibrating <= st_nxt.calibrating;
		end
	end

	ttpd_touch #(
		.CAL_SAMPLES(CAL_SAMPLES)
	) u_touch (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en_touch),
		.sample (evt_s1.sample),
		.cfg    (cfg_q),
		.st_cur (st_cur),
		.st_nxt (st_nxt)
	);

	ttpd_phase u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_zero  (en_zero),
		.en_tick  (en_tick),
		.lamp_on  (st_cur.lamp_on),
		.cfg      (cfg_q),
		.fire_cur (fire_cur),
		.fire_nxt (fire_nxt)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`TTPD_ASSERT_NEXT(a_result_follows, advance, res_valid)
	`TTPD_ASSERT_NOW(a_no_toggle_in_cal, st_cur.calibrating, !st_cur.lamp_on && !fire_cur || st_cur.calibrating && !st_cur.lamp_on)
	`TTPD_ASSERT_NEXT(a_zero_off_no_fire, en_zero && !st_cur.lamp_on, !res.fire && !fire_cur)

endmodule

### verif/touch_toggle_phase_dimmer_tb.sv
// Self-checking testbench for the touch toggle phase dimmer with a transaction scoreboard.
`timescale 1ns / 1ps

import ttpd_pkg::*;

class dimmer_scoreboard;
	bit [15:0] focus_count, relearn_limit;
	bit [7:0]  deadband, fade_on_step, fade_off_step;
	bit [9:0]  press_margin, release_margin;
	bit [14:0] off_delay_limit;
	bit [4:0]  cal_count;
	bit [20:0] cal_sum;
	bit [15:0] baseline, tracked, press_count, release_count;
	bit [15:0] tick_count, last_period, on_delay, off_delay;
	bit        lamp, fire_level;
	res_t      expected_q[$];
	int        mismatches;

	function new();
		focus_count     = 16'd1000;
		deadband        = 8'd10;
		press_margin    = 10'd50;
		release_margin  = 10'd20;
		relearn_limit   = 16'd5000;
		fade_on_step    = 8'd2;
		fade_off_step   = 8'd4;
		off_delay_limit = 15'd160;
		mismatches      = 0;
	endfunction

	function void write_reg(cfg_index_t idx, bit [15:0] data);
		case (idx)
			CFG_FOCUS:     focus_count = data;
			CFG_DEADBAND:  deadband = data[7:0];
			CFG_PRESS:     press_margin = data[9:0];
			CFG_RELEASE:   release_margin = data[9:0];
			CFG_RELEARN:   relearn_limit = data;
			CFG_FADE_ON:   fade_on_step = data[7:0];
			CFG_FADE_OFF:  fade_off_step = data[7:0];
			CFG_OFF_LIMIT: off_delay_limit = data[14:0];
			default: ;
		endcase
	endfunction

	function void note_event(evt_t e);
		int   smp, base, run;
		res_t want;
		smp = int'(e.sample);
		case (cmd_t'(e.cmd))
			CMD_TOUCH: begin
				if (cal_count < CAL_SAMPLES_DEF) begin
					cal_sum = cal_sum + e.sample;
					cal_count = cal_count + 5'd1;
					if (cal_count >= CAL_SAMPLES_DEF)
						baseline = 16'(cal_sum / CAL_SAMPLES_DEF);
				end else begin
					if (smp > int'(tracked) + int'(deadband) || tracked < deadband ||
							smp < int'(tracked) - int'(deadband))
						tracked = e.sample;
					base = int'(baseline);
					if (base < int'(press_margin) ||
							int'(tracked) < base - int'(press_margin)) begin
						release_count = '0;
						run = int'(press_count) + 1;
						if (run > int'(relearn_limit)) begin
							press_count = '0;
							baseline = tracked;
						end else begin
							press_count = 16'(run);
						end
					end else if (base >= int'(release_margin) &&
							int'(tracked) > base - int'(release_margin)) begin
						press_count = '0;
						run = int'(release_count) + 1;
						if (run > int'(relearn_limit)) begin
							release_count = '0;
							baseline = tracked;
						end else begin
							release_count = 16'(run);
						end
					end
					if (press_count == focus_count)
						lamp = ~lamp;
				end
			end
			CMD_ZERO: begin
				last_period = tick_count;
				tick_count = '0;
				if (lamp) begin
					on_delay = on_delay - {8'd0, fade_on_step};
					if ($signed(on_delay) < 0) begin
						on_delay = 16'hFFFF;
						fire_level = 1'b1;
					end else begin
						fire_level = 1'b0;
					end
				end else begin
					fire_level = 1'b0;
					if (int'($signed(off_delay)) <= int'(off_delay_limit))
						off_delay = off_delay + {8'd0, fade_off_step};
				end
			end
			CMD_TICK: begin
				tick_count = tick_count + 16'd1;
				if (lamp) begin
					if ($signed(tick_count) >= $signed(on_delay))
						fire_level = 1'b1;
					off_delay = on_delay;
				end else begin
					if (tick_count == off_delay)
						fire_level = 1'b1;
					on_delay = last_period;
				end
			end
			default: ;
		endcase
		want.fire        = fire_level;
		want.lamp_on     = lamp;
		want.calibrating = (cal_count < CAL_SAMPLES_DEF);
		expected_q.push_back(want);
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: fire=%0b lamp_on=%0b calibrating=%0b",
					got.fire, got.lamp_on, got.calibrating);
		end else begin
			want = expected_q.pop_front();
			if (got.fire !== want.fire || got.lamp_on !== want.lamp_on ||
					got.calibrating !== want.calibrating) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result error: fire/lamp_on/calibrating expected %0b/%0b/%0b, got %0b/%0b/%0b",
						want.fire, want.lamp_on, want.calibrating,
						got.fire, got.lamp_on, got.calibrating);
			end
		end
	endfunction
endclass

module touch_toggle_phase_dimmer_tb;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 75;

	typedef enum int {TM_PRESS, TM_RELEASE, TM_NEAR, TM_NOISE} touch_mode_t;
	typedef enum int {SET_ZERO, SET_FULL, SET_MIXED} cfg_style_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   evt_valid = 1'b0;
	evt_t                   evt       = '0;
	logic                   res_stall = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   evt_stall, res_valid, cfg_ready;
	res_t                   res;

	dimmer_scoreboard sb;
	int burst_left  = 0;
	int stall_left  = 0;
	int idle_cycles = 0;

	touch_toggle_phase_dimmer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			if ($urandom_range(0, 4) == 0) begin
				res_stall <= 1'b0;
				stall_left <= $urandom_range(20, 60);
			end else begin
				res_stall <= 1'($urandom_range(0, 1));
				stall_left <= $urandom_range(1, 6);
			end
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				sb.check_result(res);
			if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	function automatic bit [15:0] pick_setting(cfg_index_t idx, cfg_style_t style);
		bit [15:0] value;
		value = '0;
		if (style == SET_ZERO) begin
			value = '0;
		end else if (style == SET_FULL) begin
			value = '1;
		end else if ($urandom_range(0, 7) == 0) begin
			value = 16'($urandom_range(0, 65535));
		end else begin
			case (idx)
				CFG_FOCUS:    value = 16'($urandom_range(1, 12));
				CFG_DEADBAND: value = 16'($urandom_range(0, 40));
				CFG_PRESS:    value = 16'($urandom_range(0, 300));
				CFG_RELEASE:  value = 16'($urandom_range(0, 200));
				CFG_RELEARN:  value = 16'($urandom_range(2, 40));
				CFG_FADE_ON:  value = 16'($urandom_range(0, 24));
				CFG_FADE_OFF: value = 16'($urandom_range(0, 24));
				default:      value = 16'($urandom_range(0, 300));
			endcase
		end
		return value;
	endfunction

	function automatic bit [15:0] touch_reading(touch_mode_t mode);
		int v;
		case (mode)
			TM_PRESS:
				v = int'(sb.baseline) - int'(sb.press_margin) - 1 - int'($urandom_range(0, 200));
			TM_RELEASE:
				v = int'(sb.baseline) - int'(sb.release_margin) + 1 + int'($urandom_range(0, 100));
			TM_NEAR:
				v = int'(sb.tracked) + int'($urandom_range(0, 2 * sb.deadband + 4)) -
					int'(sb.deadband) - 2;
			default:
				v = $urandom_range(0, 65535);
		endcase
		if (v < 0)
			v = 0;
		else if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	task automatic send_event(cmd_t cmd, bit [15:0] smp);
		evt_t e;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				evt_valid <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		e.cmd = cmd;
		e.sample = smp;
		evt <= e;
		evt_valid <= 1'b1;
		@(posedge clk);
		while (evt_stall)
			@(posedge clk);
		sb.note_event(e);
	endtask

	task automatic drain_results();
		evt_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	task automatic configure(cfg_style_t style);
		bit [15:0]  value;
		cfg_index_t idx;
		for (int i = 0; i < 8; i++) begin
			idx = cfg_index_t'(i);
			value = pick_setting(idx, style);
			cfg_index <= idx;
			cfg_data <= value;
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.write_reg(idx, value);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(int count);
		touch_mode_t mode;
		int          sent, touch_left, ticks_left, pick;
		mode = TM_NOISE;
		sent = 0;
		touch_left = 0;
		ticks_left = $urandom_range(0, 16);
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				send_event(CMD_NONE, 16'($urandom_range(0, 65535)));
			end else begin
				if (pick < 50) begin
					if (touch_left == 0) begin
						mode = touch_mode_t'($urandom_range(0, 3));
						touch_left = $urandom_range(1, 40);
					end
					touch_left--;
					send_event(CMD_TOUCH, touch_reading(mode));
				end else if (ticks_left == 0) begin
					send_event(CMD_ZERO, 16'($urandom_range(0, 65535)));
					if ($urandom_range(0, 29) == 0)
						ticks_left = $urandom_range(100, 250);
					else
						ticks_left = $urandom_range(0, 16);
				end else begin
					send_event(CMD_TICK, 16'($urandom_range(0, 65535)));
					ticks_left--;
				end
				sent++;
			end
		end
	endtask

	initial begin
		cfg_style_t style;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(CMD_NONE, 16'hFFFF);
		send_event(CMD_ZERO, 16'h0000);
		send_event(CMD_TICK, 16'h5A5A);
		for (int i = 0; i < CAL_SAMPLES_DEF; i++) begin
			if (i == 10)
				send_event(CMD_NONE, 16'h0000);
			if (i == 0)
				send_event(CMD_TOUCH, 16'hFFFF);
			else if (i == 1)
				send_event(CMD_TOUCH, 16'h0000);
			else
				send_event(CMD_TOUCH, 16'($urandom_range(990, 1010)));
		end
		send_event(CMD_TOUCH, 16'h0000);
		send_event(CMD_TOUCH, 16'hFFFF);
		send_event(CMD_ZERO, 16'h0000);
		drain_results();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				style = SET_ZERO;
			else if (p == 1)
				style = SET_FULL;
			else
				style = SET_MIXED;
			configure(style);
			run_phase(PHASE_ITEMS);
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
